@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ghd_pkg.sv @@
package ghd_pkg;

  localparam int AccW = 21;
  localparam int CntW = 4;

  localparam int BaseYear    = 1999;
  localparam int DaysQuad    = 1461;
  localparam int DaysYear    = 365;
  localparam int EpochOffset = 227016 + 13 + 5;
  localparam int DaysCycle30 = 10631;
  localparam int HijriYear   = 354;
  localparam int HijriMod    = 1400;
  localparam int ScaledYear  = 1063100 / 30;
  localparam int Hundred     = 100;
  localparam int LastMonth   = 11;

  localparam logic [CntW-1:0] CycBits   = CntW'(5);
  localparam logic [CntW-1:0] YearBits  = CntW'(4);
  localparam logic [CntW-1:0] ScaleBits = CntW'(4);
  localparam logic [CntW-1:0] HundBits  = CntW'(8);

  localparam logic [CntW-1:0] AdjAddrIdx = CntW'(0);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_SUM,
    ST_DIV_CYC,
    ST_DIV_YEAR,
    ST_YEAR_ADD,
    ST_YEAR_MOD,
    ST_SCALE,
    ST_MOD_SCALED,
    ST_DIV_HUND,
    ST_WALK_INIT,
    ST_WALK,
    ST_DONE
  } ghd_state_t;

  typedef struct packed {
    ghd_state_t      state;
    logic [CntW-1:0] cnt;
    logic            in_ready;
    logic            walk_stop;
    logic            out_load;
  } ghd_ctl_t;

  function automatic logic [8:0] greg_cum(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12,
      4'd13,
      4'd14,
      4'd15:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] hijri_len(input logic [CntW-1:0] i);
    return i[0] ? 5'd29 : 5'd30;
  endfunction

endpackage

@@ hw/rtl/ghd_sub_unit.sv @@
module ghd_sub_unit (
  input  logic [ghd_pkg::AccW-1:0] a,
  input  logic [ghd_pkg::AccW-1:0] b,
  output logic [ghd_pkg::AccW-1:0] diff,
  output logic                     ge
);

  logic [ghd_pkg::AccW:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[ghd_pkg::AccW-1:0];
  assign ge   = ~wide[ghd_pkg::AccW];

endmodule

@@ hw/rtl/ghd_ctrl.sv @@
module ghd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              ge,
  input  logic              out_free,
  output ghd_pkg::ghd_ctl_t ctl
);

  ghd_pkg::ghd_state_t          state_r, state_nxt;
  logic [ghd_pkg::CntW-1:0]     cnt_r, cnt_nxt;
  logic                         walk_stop;

  assign walk_stop = ~ge | (cnt_r == ghd_pkg::CntW'(ghd_pkg::LastMonth));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ghd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ghd_pkg::ST_BASE;
      end
      ghd_pkg::ST_BASE: state_nxt = ghd_pkg::ST_SUM;
      ghd_pkg::ST_SUM: begin
        state_nxt = ghd_pkg::ST_DIV_CYC;
        cnt_nxt   = ghd_pkg::CycBits;
      end
      ghd_pkg::ST_DIV_CYC: begin
        if (cnt_r == '0) begin
          state_nxt = ghd_pkg::ST_DIV_YEAR;
          cnt_nxt   = ghd_pkg::YearBits;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ghd_pkg::ST_DIV_YEAR: begin
        if (cnt_r == '0) state_nxt = ghd_pkg::ST_YEAR_ADD;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ghd_pkg::ST_YEAR_ADD: state_nxt = ghd_pkg::ST_YEAR_MOD;
      ghd_pkg::ST_YEAR_MOD: state_nxt = ghd_pkg::ST_SCALE;
      ghd_pkg::ST_SCALE: begin
        state_nxt = ghd_pkg::ST_MOD_SCALED;
        cnt_nxt   = ghd_pkg::ScaleBits;
      end
      ghd_pkg::ST_MOD_SCALED: begin
        if (cnt_r == '0) begin
          state_nxt = ghd_pkg::ST_DIV_HUND;
          cnt_nxt   = ghd_pkg::HundBits;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ghd_pkg::ST_DIV_HUND: begin
        if (cnt_r == '0) state_nxt = ghd_pkg::ST_WALK_INIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ghd_pkg::ST_WALK_INIT: begin
        state_nxt = ghd_pkg::ST_WALK;
        cnt_nxt   = '0;
      end
      ghd_pkg::ST_WALK: begin
        if (walk_stop) state_nxt = ghd_pkg::ST_DONE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ghd_pkg::ST_DONE: begin
        if (out_free) state_nxt = ghd_pkg::ST_IDLE;
      end
      default: state_nxt = ghd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.state     = state_r;
    ctl.cnt       = cnt_r;
    ctl.in_ready  = (state_r == ghd_pkg::ST_IDLE);
    ctl.walk_stop = walk_stop;
    ctl.out_load  = (state_r == ghd_pkg::ST_DONE) & out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ghd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/gregorian_to_hijri_date_core.sv @@
// The time from an accepted input word to out_tvalid depends on the month walk and on out_tready.
// One word is converted at a time; in_tready is high only between items.
// A single compare-subtract unit runs every division, modulo and month-table step in turn.
// Reset (rst_n low at a clock edge) returns to idle, drops any pending output and sets
// day_adjust to 5.
module gregorian_to_hijri_date_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // greg_year[6:0], greg_month[10:7], greg_date[15:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // hijri_year[10:0], hijri_month[14:11], hijri_date[19:15], zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int W = ghd_pkg::AccW;

  ghd_pkg::ghd_ctl_t ctl;

  logic [6:0]   y_r;
  logic [3:0]   m_r;
  logic [4:0]   d_r;
  logic [7:0]   adj_r;
  logic [W-1:0] acc_r, acc_nxt;
  logic [8:0]   qsh_r, qsh_nxt;
  logic [5:0]   cyc_r, cyc_nxt;
  logic [13:0]  rem_r, rem_nxt;
  logic [10:0]  year_r, year_nxt;
  logic [3:0]   month_r, month_nxt;
  logic [4:0]   date_r, date_nxt;
  logic         out_valid_r;
  logic [10:0]  oyear_r;
  logic [3:0]   omonth_r;
  logic [4:0]   odate_r;

  logic [W-1:0] sub_b, diff;
  logic         ge;
  logic         out_free;
  logic         in_acc;
  logic         cfg_wr;
  logic [11:0]  full;
  logic         leap;
  logic [W-1:0] kept;

  assign in_acc   = in_tvalid & ctl.in_ready;
  assign out_free = ~out_valid_r | out_tready;
  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  ghd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .ge       (ge),
    .out_free (out_free),
    .ctl      (ctl)
  );

  ghd_sub_unit u_sub (
    .a    (acc_r),
    .b    (sub_b),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    case (ctl.state)
      ghd_pkg::ST_DIV_CYC:    sub_b = W'(ghd_pkg::DaysCycle30) << ctl.cnt;
      ghd_pkg::ST_DIV_YEAR:   sub_b = W'(ghd_pkg::HijriYear) << ctl.cnt;
      ghd_pkg::ST_YEAR_MOD:   sub_b = W'(ghd_pkg::HijriMod);
      ghd_pkg::ST_MOD_SCALED: sub_b = W'(ghd_pkg::ScaledYear) << ctl.cnt;
      ghd_pkg::ST_DIV_HUND:   sub_b = W'(ghd_pkg::Hundred) << ctl.cnt;
      ghd_pkg::ST_WALK:       sub_b = W'(ghd_pkg::hijri_len(ctl.cnt));
      default:                sub_b = '0;
    endcase
  end

  assign full = 12'(y_r) + 12'(ghd_pkg::BaseYear);
  assign leap = (y_r[1:0] == 2'd0) & (y_r != 7'd100);
  assign kept = ge ? diff : acc_r;

  always_comb begin
    acc_nxt   = acc_r;
    qsh_nxt   = qsh_r;
    cyc_nxt   = cyc_r;
    rem_nxt   = rem_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    date_nxt  = date_r;
    case (ctl.state)
      ghd_pkg::ST_BASE: begin
        acc_nxt = W'(W'(full[11:2]) * W'(ghd_pkg::DaysQuad))
                + W'(W'(full[1:0]) * W'(ghd_pkg::DaysYear));
      end
      ghd_pkg::ST_SUM: begin
        acc_nxt = acc_r + W'(ghd_pkg::greg_cum(m_r)) + W'(d_r) + W'(adj_r) + W'(leap)
                - W'(ghd_pkg::EpochOffset);
        qsh_nxt = '0;
      end
      ghd_pkg::ST_DIV_CYC: begin
        acc_nxt = kept;
        if (ctl.cnt == '0) begin
          cyc_nxt = {qsh_r[4:0], ge};
          rem_nxt = kept[13:0];
          qsh_nxt = '0;
        end else begin
          qsh_nxt = {qsh_r[7:0], ge};
        end
      end
      ghd_pkg::ST_DIV_YEAR: begin
        acc_nxt = kept;
        qsh_nxt = {qsh_r[7:0], ge};
      end
      ghd_pkg::ST_YEAR_ADD: begin
        acc_nxt = W'({cyc_r, 5'd0}) - W'({cyc_r, 1'b0}) + W'(qsh_r[4:0]);
      end
      ghd_pkg::ST_YEAR_MOD: begin
        year_nxt = kept[10:0] + 11'd1;
      end
      ghd_pkg::ST_SCALE: begin
        acc_nxt = W'(W'(rem_r) * W'(ghd_pkg::Hundred));
        qsh_nxt = '0;
      end
      ghd_pkg::ST_MOD_SCALED: begin
        acc_nxt = kept;
      end
      ghd_pkg::ST_DIV_HUND: begin
        acc_nxt = kept;
        qsh_nxt = {qsh_r[7:0], ge};
      end
      ghd_pkg::ST_WALK_INIT: begin
        acc_nxt = (qsh_r == '0) ? '0 : W'(qsh_r - 9'd1);
      end
      ghd_pkg::ST_WALK: begin
        if (ctl.walk_stop) begin
          month_nxt = ctl.cnt;
          date_nxt  = acc_r[4:0] + 5'd1;
        end else begin
          acc_nxt = diff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    qsh_r   <= qsh_nxt;
    cyc_r   <= cyc_nxt;
    rem_r   <= rem_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    date_r  <= date_nxt;
    if (in_acc) begin
      y_r <= in_tdata[6:0];
      m_r <= in_tdata[10:7];
      d_r <= in_tdata[15:11];
    end
    if (ctl.out_load) begin
      oyear_r  <= year_r;
      omonth_r <= month_r;
      odate_r  <= date_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      adj_r       <= 8'd5;
    end else begin
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_wr && (cfg_paddr[2] == ghd_pkg::AdjAddrIdx[0])) adj_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready  = ctl.in_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, odate_r, omonth_r, oyear_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ghd_pkg::AdjAddrIdx[0]) ? {24'd0, adj_r} : 32'd0;

endmodule

@@ hw/rtl/ghd_core_chk.sv @@
`include "assert_macros.svh"

module ghd_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

  `CHK_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accepting a word")

  `CHK_NEXT(a_no_instant_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result appeared one cycle after accept")

  `CHK_IMPLY(a_out_range, out_tvalid, out_tdata[10:0] >= 11'd1 && out_tdata[10:0] <= 11'd1400 && out_tdata[14:11] <= 4'd11 && out_tdata[19:15] >= 5'd1 && out_tdata[19:15] <= 5'd30 && out_tdata[23:20] == 4'd0, "output fields out of range")

endmodule

bind gregorian_to_hijri_date_core ghd_core_chk u_ghd_core_chk (.*);

@@ dv/gregorian_to_hijri_date_core_tb.sv @@
`default_nettype none

module gregorian_to_hijri_date_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GREG_BASE_YEAR   = 1999;
  localparam int DAYS_PER_QUAD    = 1461;
  localparam int DAYS_PER_YEAR    = 365;
  localparam int EPOCH_DAYS       = 227016 + 13;
  localparam int DAYS_PER_CYCLE30 = 10631;
  localparam int HIJRI_YEAR_DAYS  = 354;
  localparam int HIJRI_YEAR_MOD   = 1400;
  localparam int SCALED_YEAR      = 1063100 / 30;
  localparam int DRAIN_SLACK      = 60;
  localparam int CYCLE_LIMIT      = 400000;

  localparam logic [2:0] ADJ_ADDR   = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } greg_t;

  typedef struct packed {
    logic [4:0]  date;
    logic [3:0]  month;
    logic [10:0] year;
  } hijri_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // greg_year[6:0], greg_month[10:7], greg_date[15:11]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // hijri_year[10:0], hijri_month[14:11], hijri_date[19:15]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hijri_t     pending_hijri[$];
  logic [7:0] adj_model = 8'd5;
  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  int         sink_hold = 0;
  int         mismatch_cnt = 0;
  int         dates_sent = 0;
  int         dates_checked = 0;
  int         adjust_writes = 0;
  int         cycle_cnt = 0;

  gregorian_to_hijri_date_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_hijri.size());
      $display("gregorian_to_hijri_date_core regression: fail");
      $finish;
    end
  end

  function automatic int greg_month_len(input int idx);
    case (idx)
      1:           return 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic greg_t greg(input int y, input int m, input int d);
    greg_t g;
    g.year  = 7'(y);
    g.month = 4'(m);
    g.date  = 5'(d);
    return g;
  endfunction

  function automatic greg_t random_calendar_date();
    int y;
    int m;
    int last;
    y = $urandom_range(0, 99);
    m = $urandom_range(1, 12);
    last = greg_month_len(m - 1) + ((m == 2 && y % 4 == 0) ? 1 : 0);
    return greg(y, m, $urandom_range(1, last));
  endfunction

  function automatic hijri_t hijri_from_greg(input greg_t g, input logic [7:0] adj,
                                             output int doy);
    hijri_t h;
    int yr;
    int full;
    int days;
    int months_before;
    int rem;
    int hyear;
    int cum;
    int hmonth;
    int hdate;
    int i;
    yr = int'(g.year);
    full = yr + GREG_BASE_YEAR;
    days = (full / 4) * DAYS_PER_QUAD + (full % 4) * DAYS_PER_YEAR;
    months_before = (g.month == 4'd0) ? 0 : int'(g.month) - 1;
    if (months_before > 11) months_before = 11;
    for (i = 0; i < months_before; i++) days += greg_month_len(i);
    days = days + int'(g.date) + int'(adj) - 5;
    if ((yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0))) days++;
    days = days - EPOCH_DAYS;
    rem = days % DAYS_PER_CYCLE30;
    hyear = ((((days / DAYS_PER_CYCLE30) & 32'hFFFF) * 30 + rem / HIJRI_YEAR_DAYS)
             % HIJRI_YEAR_MOD) + 1;
    doy = ((rem * 100) % SCALED_YEAR) / 100;
    cum = 0;
    hmonth = 11;
    for (i = 0; i < 12; i++) begin
      if (cum + (i % 2 == 0 ? 30 : 29) >= doy) begin
        hmonth = i;
        break;
      end
      cum += (i % 2 == 0 ? 30 : 29);
    end
    hdate = doy - cum;
    if (hdate == 0) hdate = 1;
    h.year  = 11'(hyear);
    h.month = 4'(hmonth);
    h.date  = 5'(hdate);
    return h;
  endfunction

  task automatic report(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    hijri_t want;
    hijri_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = hijri_t'(out_tdata[19:0]);
      dates_checked++;
      if (pending_hijri.size() == 0) begin
        report($sformatf("unexpected hijri word %h", out_tdata));
      end else begin
        want = pending_hijri.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.date !== want.date ||
            out_tdata[23:20] !== 4'd0) begin
          report($sformatf("hijri mismatch: exp y=%0d m=%0d d=%0d, got y=%0d m=%0d d=%0d pad=%h",
                           want.year, want.month, want.date,
                           got.year, got.month, got.date, out_tdata[23:20]));
        end
      end
    end
  end

  initial begin
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_date(input greg_t g);
    int doy;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= g;
    do @(posedge clk); while (!in_tready);
    pending_hijri.push_back(hijri_from_greg(g, adj_model, doy));
    dates_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_hijri.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_adjust(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, addr, value, rd);
    if (addr == ADJ_ADDR) adj_model = value[7:0];
    adjust_writes++;
    apb_access(1'b0, ADJ_ADDR, 32'h0, rd);
    if (rd[7:0] !== adj_model)
      report($sformatf("day_adjust readback: expected %0d, got %0d", adj_model, rd[7:0]));
  endtask

  task automatic test_calendar_edges();
    send_date(greg(0, 1, 1));
    send_date(greg(99, 12, 31));
    send_date(greg(0, 2, 29));
    send_date(greg(4, 2, 29));
    send_date(greg(100, 3, 1));
    send_date(greg(127, 15, 31));
    send_date(greg(96, 0, 0));
    send_date(greg(64, 13, 0));
    send_date(greg(1, 14, 15));
    send_date(greg(50, 7, 31));
    send_date(greg(24, 2, 30));
    send_date(greg(3, 11, 31));
    send_date(greg(100, 2, 28));
    send_date(greg(0, 12, 31));
    send_date(greg(99, 1, 1));
    send_date(greg(127, 0, 1));
  endtask

  task automatic test_hijri_day_boundaries();
    int targets[5];
    int k;
    int y;
    int m;
    int d;
    int doy;
    bit found;
    greg_t g;
    targets = '{0, 1, 29, 30, 354};
    for (k = 0; k < 5; k++) begin
      found = 1'b0;
      for (y = 0; y < 100 && !found; y++)
        for (m = 1; m <= 12 && !found; m++)
          for (d = 1; d <= 28 && !found; d++) begin
            void'(hijri_from_greg(greg(y, m, d), adj_model, doy));
            if (doy == targets[k]) begin
              g = greg(y, m, d);
              found = 1'b1;
            end
          end
      if (found) send_date(g);
    end
  endtask

  task automatic test_adjust_extremes();
    logic [31:0] settings[3];
    int k;
    int n;
    settings = '{32'h0000_0000, 32'h0000_00FF, 32'hFFFF_FF3C};
    for (k = 0; k < 3; k++) begin
      set_adjust(ADJ_ADDR, settings[k]);
      for (n = 0; n < 10; n++) send_date(random_calendar_date());
    end
    set_adjust(SPARE_ADDR, 32'h0000_00C8);
    for (n = 0; n < 6; n++) send_date(random_calendar_date());
  endtask

  task automatic test_random_dates();
    int phase;
    int n;
    for (phase = 0; phase < 4; phase++) begin
      set_adjust(ADJ_ADDR, $urandom);
      for (n = 0; n < 180; n++) begin
        if ($urandom_range(0, 99) < 85)
          send_date(random_calendar_date());
        else
          send_date(greg_t'(16'($urandom)));
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    drain_results();
    sink_hold = 300;
    for (n = 0; n < 5; n++) send_date(random_calendar_date());
    drain_results();
  endtask

  task automatic test_gapless_stream();
    int n;
    set_adjust(ADJ_ADDR, $urandom_range(0, 255));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    for (n = 0; n < 60; n++) send_date(random_calendar_date());
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calendar_edges();
    test_hijri_day_boundaries();
    test_adjust_extremes();
    test_random_dates();
    test_output_backpressure();
    test_gapless_stream();
    drain_results();
    $display("converted %0d dates, %0d results checked, %0d register writes, %0d mismatches",
             dates_sent, dates_checked, adjust_writes, mismatch_cnt);
    $display("calendar edges, hijri day boundaries, adjust extremes, stalls and gap-free flow");
    if (mismatch_cnt == 0) begin
      $display("gregorian_to_hijri_date_core regression: pass");
    end else begin
      $display("gregorian_to_hijri_date_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
